>>> rtl/bps_pkg.sv
`timescale 1ns / 1ps

package bps_pkg;

  // Payload widths
  localparam int OP_W    = 2;
  localparam int PAT_W   = 4;
  localparam int TIME_W  = 64;
  localparam int WRAP_W  = 16;
  localparam int LEVEL_W = 15;
  localparam int CLK_W   = 29;

  // Sequence limits
  localparam int MAX_NOTES = 8;
  localparam int CNT_W     = $clog2(MAX_NOTES + 1);
  localparam int LEN_W     = 3;

  // Tone divider: sys_clock / (64 * hz) taken as (sys_clock >> 6) / hz
  localparam int TONE_DIV   = 64;
  localparam int DIV_SHIFT  = $clog2(TONE_DIV);
  localparam int DIV_W      = CLK_W - DIV_SHIFT;
  localparam int HZ_LOW     = 1200;
  localparam int HZ_MID     = 1800;
  localparam int HZ_HIGH    = 2600;
  localparam int QUOT_W     = $clog2(((1 << CLK_W) - 1) / (TONE_DIV * HZ_LOW) + 1);
  localparam int TONE_LANES = 3;
  localparam int LANE_W     = $clog2(TONE_LANES);

  // floor(x / hz) = (x * ceil(2^s / hz)) >> s for x below 2^DIV_W,
  // with s = DIV_W + clog2(hz)
  localparam int RECIP_W       = DIV_W + 1;
  localparam int PROD_W        = DIV_W + RECIP_W;
  localparam int RECIP_SH_LOW  = DIV_W + $clog2(HZ_LOW);
  localparam int RECIP_SH_MID  = DIV_W + $clog2(HZ_MID);
  localparam int RECIP_SH_HIGH = DIV_W + $clog2(HZ_HIGH);
  localparam logic [RECIP_W-1:0] RECIP_LOW  =
    RECIP_W'(((64'd1 << RECIP_SH_LOW) + 64'(HZ_LOW) - 64'd1) / 64'(HZ_LOW));
  localparam logic [RECIP_W-1:0] RECIP_MID  =
    RECIP_W'(((64'd1 << RECIP_SH_MID) + 64'(HZ_MID) - 64'd1) / 64'(HZ_MID));
  localparam logic [RECIP_W-1:0] RECIP_HIGH =
    RECIP_W'(((64'd1 << RECIP_SH_HIGH) + 64'(HZ_HIGH) - 64'd1) / 64'(HZ_HIGH));

  localparam int RST_CLK_HZ = 125000000;
  localparam logic [QUOT_W-1:0] QUOT_RST_LOW  = QUOT_W'(RST_CLK_HZ / (TONE_DIV * HZ_LOW));
  localparam logic [QUOT_W-1:0] QUOT_RST_MID  = QUOT_W'(RST_CLK_HZ / (TONE_DIV * HZ_MID));
  localparam logic [QUOT_W-1:0] QUOT_RST_HIGH = QUOT_W'(RST_CLK_HZ / (TONE_DIV * HZ_HIGH));
  localparam logic [WRAP_W-1:0] WRAP_RST      = '1;

  // Note durations held directly in microseconds
  localparam int DUR_W = 19;

  // Command queue
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_PLAY = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // Pattern codes
  localparam logic [PAT_W-1:0] PAT_NONE           = 4'd0;
  localparam logic [PAT_W-1:0] PAT_STARTED        = 4'd1;
  localparam logic [PAT_W-1:0] PAT_PAUSED         = 4'd2;
  localparam logic [PAT_W-1:0] PAT_RESUMED        = 4'd3;
  localparam logic [PAT_W-1:0] PAT_RESET          = 4'd4;
  localparam logic [PAT_W-1:0] PAT_REJECTED       = 4'd5;
  localparam logic [PAT_W-1:0] PAT_ALARM_ON       = 4'd6;
  localparam logic [PAT_W-1:0] PAT_ALARM_OFF      = 4'd7;
  localparam logic [PAT_W-1:0] PAT_SETTINGS_OPEN  = 4'd8;
  localparam logic [PAT_W-1:0] PAT_SETTINGS_SAVED = 4'd9;

  typedef enum logic [1:0] {
    TONE_SILENT = 2'd0,
    TONE_LOW    = 2'd1,
    TONE_MID    = 2'd2,
    TONE_HIGH   = 2'd3
  } tone_code_t;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_PLAY  = 3'd1,
    CMD_CLEAR = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_NOP   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    tone_code_t         code;
    logic [DUR_W-1:0]   dur_us;
  } note_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PAT_W-1:0]   pat;
    logic [CNT_W-1:0]   cnt;
    logic               loop_en;
    logic [TIME_W-1:0]  now_us;
  } cmd_t;

  typedef struct packed {
    logic                               busy;
    logic [TONE_LANES-1:0][QUOT_W-1:0]  quot;
  } tone_div_t;

  function automatic logic [LEN_W-1:0] rom_len(input logic [PAT_W-1:0] pat);
    logic [LEN_W-1:0] len;
    len = '0;
    unique case (pat)
      PAT_STARTED:        len = 3'd3;
      PAT_PAUSED:         len = 3'd1;
      PAT_RESUMED:        len = 3'd1;
      PAT_RESET:          len = 3'd5;
      PAT_REJECTED:       len = 3'd1;
      PAT_ALARM_ON:       len = 3'd6;
      PAT_ALARM_OFF:      len = 3'd1;
      PAT_SETTINGS_OPEN:  len = 3'd3;
      PAT_SETTINGS_SAVED: len = 3'd3;
      default:            len = '0;
    endcase
    return len;
  endfunction

  function automatic note_t mk_note(input tone_code_t code, input logic [DUR_W-1:0] dur_us);
    note_t n;
    n.code   = code;
    n.dur_us = dur_us;
    return n;
  endfunction

  function automatic note_t note_rom(input logic [PAT_W-1:0] pat,
                                    input logic [CNT_W-1:0] idx);
    note_t n;
    n = mk_note(TONE_SILENT, '0);
    unique case (pat)
      PAT_STARTED: begin
        unique case (idx)
          0:       n = mk_note(TONE_MID, 19'd45000);
          1:       n = mk_note(TONE_SILENT, 19'd30000);
          2:       n = mk_note(TONE_HIGH, 19'd70000);
          default: n = mk_note(TONE_SILENT, '0);
        endcase
      end
      PAT_PAUSED:    if (idx == '0) n = mk_note(TONE_LOW, 19'd70000);
      PAT_RESUMED:   if (idx == '0) n = mk_note(TONE_HIGH, 19'd55000);
      PAT_RESET: begin
        unique case (idx)
          0:       n = mk_note(TONE_MID, 19'd40000);
          1:       n = mk_note(TONE_SILENT, 19'd25000);
          2:       n = mk_note(TONE_HIGH, 19'd40000);
          3:       n = mk_note(TONE_SILENT, 19'd25000);
          4:       n = mk_note(TONE_HIGH, 19'd90000);
          default: n = mk_note(TONE_SILENT, '0);
        endcase
      end
      PAT_REJECTED:  if (idx == '0) n = mk_note(TONE_LOW, 19'd180000);
      PAT_ALARM_ON: begin
        unique case (idx)
          0, 2, 4: n = mk_note(TONE_HIGH, 19'd120000);
          1, 3:    n = mk_note(TONE_SILENT, 19'd90000);
          5:       n = mk_note(TONE_SILENT, 19'd500000);
          default: n = mk_note(TONE_SILENT, '0);
        endcase
      end
      PAT_ALARM_OFF: if (idx == '0) n = mk_note(TONE_MID, 19'd50000);
      PAT_SETTINGS_OPEN: begin
        unique case (idx)
          0, 2:    n = mk_note(TONE_MID, 19'd40000);
          1:       n = mk_note(TONE_SILENT, 19'd40000);
          default: n = mk_note(TONE_SILENT, '0);
        endcase
      end
      PAT_SETTINGS_SAVED: begin
        unique case (idx)
          0:       n = mk_note(TONE_HIGH, 19'd45000);
          1:       n = mk_note(TONE_SILENT, 19'd25000);
          2:       n = mk_note(TONE_MID, 19'd70000);
          default: n = mk_note(TONE_SILENT, '0);
        endcase
      end
      default: n = mk_note(TONE_SILENT, '0);
    endcase
    return n;
  endfunction

endpackage

>>> rtl/bps_if.sv
`timescale 1ns / 1ps

interface bps_in_if;
  logic                        valid;
  logic                        ready;
  logic [bps_pkg::OP_W-1:0]    operation;
  logic [bps_pkg::PAT_W-1:0]   pattern;
  logic [bps_pkg::TIME_W-1:0]  now_us;

  modport source (output valid, output operation, output pattern, output now_us,
                  input ready);
  modport sink   (input valid, input operation, input pattern, input now_us,
                  output ready);
endinterface

interface bps_out_if;
  logic                         valid;
  logic                         ready;
  logic [bps_pkg::WRAP_W-1:0]   tone_wrap;
  logic [bps_pkg::LEVEL_W-1:0]  tone_level;
  logic                         playing;
  logic                         reprogrammed;

  modport source (output valid, output tone_wrap, output tone_level, output playing,
                  output reprogrammed, input ready);
  modport sink   (input valid, input tone_wrap, input tone_level, input playing,
                  input reprogrammed, output ready);
endinterface

>>> rtl/buzzer_pattern_sequencer.sv
`timescale 1ns / 1ps

// Buzzer pattern sequencer.
// in_chan takes tick, play and stop items (operation, pattern, now_us) on a
// valid/ready transfer; out_chan returns exactly one result per item: PWM
// wrap and level, a playing flag and whether the tone was reprogrammed.
// cfg_we/cfg_wdata write the system clock frequency in Hz.
// Each item is registered in the command queue and then in the result
// register before it appears on out_chan.
// Throughput: one item per cycle while out_chan is not stalled and the
// tone quotients are not being rebuilt; the back-end note sequencer
// updates all its state per item, so a tick may follow a play back to back.
// A two-entry command queue parts the front classifier from the back end,
// and the result register parts the back end from the receiver: while
// out_chan is stalled, up to two more items are still taken, then
// in_chan.ready drops until the receiver takes a result.
// A config write rebuilds the three tone quotients by reciprocal
// multiplication from the registered dividend; in_chan.ready stays low
// during the write and while the rebuild is in progress.
// Reset loads the quotients for a 125 MHz clock directly, so the block
// takes items from the first cycle after reset; wrap resets to 65535,
// level to 0, and no pattern is playing.

module buzzer_pattern_sequencer (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bps_pkg::CLK_W-1:0]  cfg_wdata,
  bps_in_if.sink                     in_chan,
  bps_out_if.source                  out_chan
);
  import bps_pkg::*;

  tone_div_t div;
  cmd_t      push_cmd;
  cmd_t      head_cmd;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  // tone quotients, rebuilt after each config write
  bps_tone_div u_tone_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .div       (div)
  );

  // decode and classify incoming items
  bps_front u_front (
    .cfg_we  (cfg_we),
    .div     (div),
    .q_full  (q_full),
    .in_chan (in_chan),
    .push    (push),
    .cmd     (push_cmd)
  );

  bps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  // note sequencer and result register
  bps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (head_cmd),
    .div       (div),
    .cmd_pop   (pop),
    .out_chan  (out_chan)
  );

  // no transfer while the quotients are being rebuilt
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div.busy |-> !in_chan.ready)
    else $error("input taken while tone divider busy");

  a_cfg_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> div.busy)
    else $error("config write did not start tone divider");

  // a sounding tone only ever belongs to an active note
  a_level_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.tone_level != '0) |-> out_chan.playing)
    else $error("non-zero level reported with no note playing");

  a_queue_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue overrun");

endmodule

>>> rtl/bps_tone_div.sv
`timescale 1ns / 1ps

module bps_tone_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bps_pkg::CLK_W-1:0]  cfg_wdata,
  output bps_pkg::tone_div_t         div
);
  import bps_pkg::*;

  logic                    busy_r;
  logic [DIV_W-1:0]        dvd_r;
  logic [QUOT_W-1:0]       quot_r [TONE_LANES];
  logic [PROD_W-1:0]       prod   [TONE_LANES];

  // reciprocal multiply per lane, from the registered dividend
  always_comb begin
    prod[0] = PROD_W'(dvd_r) * PROD_W'(RECIP_LOW);
    prod[1] = PROD_W'(dvd_r) * PROD_W'(RECIP_MID);
    prod[2] = PROD_W'(dvd_r) * PROD_W'(RECIP_HIGH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      quot_r[0] <= QUOT_RST_LOW;
      quot_r[1] <= QUOT_RST_MID;
      quot_r[2] <= QUOT_RST_HIGH;
    end else if (cfg_we) begin
      busy_r <= 1'b1;
      dvd_r  <= cfg_wdata[CLK_W-1:DIV_SHIFT];
    end else if (busy_r) begin
      busy_r    <= 1'b0;
      quot_r[0] <= QUOT_W'(prod[0] >> RECIP_SH_LOW);
      quot_r[1] <= QUOT_W'(prod[1] >> RECIP_SH_MID);
      quot_r[2] <= QUOT_W'(prod[2] >> RECIP_SH_HIGH);
    end
  end

  always_comb begin
    div.busy = busy_r;
    for (int l = 0; l < TONE_LANES; l++) div.quot[l] = quot_r[l];
  end

endmodule

>>> rtl/bps_front.sv
`timescale 1ns / 1ps

module bps_front (
  input  logic                cfg_we,
  input  bps_pkg::tone_div_t  div,
  input  logic                q_full,
  bps_in_if.sink              in_chan,
  output logic                push,
  output bps_pkg::cmd_t       cmd
);
  import bps_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NOTES);

  logic [CNT_W-1:0] len_ext;

  // hold off while the queue is full or the tone table is being rebuilt
  assign in_chan.ready = !q_full && !div.busy && !cfg_we;
  assign push          = in_chan.valid && in_chan.ready;

  always_comb begin
    len_ext     = CNT_W'(rom_len(in_chan.pattern));
    cmd.pat     = in_chan.pattern;
    cmd.cnt     = (len_ext > MAX_CNT) ? MAX_CNT : len_ext;
    cmd.loop_en = (in_chan.pattern == PAT_ALARM_ON);
    cmd.now_us  = in_chan.now_us;
    priority if (in_chan.operation == OP_TICK) begin
      cmd.kind = CMD_TICK;
    end else if (in_chan.operation == OP_PLAY) begin
      // out-of-range codes behave like pattern none
      if (in_chan.pattern == PAT_NONE || in_chan.pattern > PAT_SETTINGS_SAVED) begin
        cmd.kind = CMD_CLEAR;
      end else begin
        cmd.kind = CMD_PLAY;
      end
    end else if (in_chan.operation == OP_STOP) begin
      cmd.kind = CMD_STOP;
    end else begin
      cmd.kind = CMD_NOP;
    end
  end

endmodule

>>> rtl/bps_queue.sv
`timescale 1ns / 1ps

module bps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  bps_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output bps_pkg::cmd_t  head
);
  import bps_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (!push && pop) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

>>> rtl/bps_back.sv
`timescale 1ns / 1ps

module bps_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  input  bps_pkg::cmd_t       cmd,
  input  bps_pkg::tone_div_t  div,
  output logic                cmd_pop,
  bps_out_if.source           out_chan
);
  import bps_pkg::*;

  logic [PAT_W-1:0]   pat_r,      pat_nxt;
  logic [CNT_W-1:0]   cnt_r,      cnt_nxt;
  logic [CNT_W-1:0]   idx_r,      idx_nxt;
  logic               loop_r,     loop_nxt;
  logic [TIME_W-1:0]  deadline_r, deadline_nxt;
  logic [WRAP_W-1:0]  wrap_r,     wrap_nxt;
  logic [LEVEL_W-1:0] level_r,    level_nxt;
  logic               out_valid_r;
  logic               playing_r;
  logic               reprog_r;

  logic               reprog;
  logic               start;
  logic [PAT_W-1:0]   sel_pat;
  logic [CNT_W-1:0]   sel_idx;
  logic [CNT_W-1:0]   idx_inc;
  logic               due;
  note_t              note;
  logic [LANE_W-1:0]  lane;
  logic [QUOT_W-1:0]  quot;

  assign cmd_pop = cmd_valid && (!out_valid_r || out_chan.ready);
  assign due     = (cmd.now_us >= deadline_r);
  assign idx_inc = idx_r + 1'b1;

  always_comb begin
    pat_nxt      = pat_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    loop_nxt     = loop_r;
    deadline_nxt = deadline_r;
    wrap_nxt     = wrap_r;
    level_nxt    = level_r;
    reprog       = 1'b0;
    start        = 1'b0;
    sel_pat      = pat_r;
    sel_idx      = '0;

    unique case (cmd.kind)
      CMD_CLEAR: begin
        pat_nxt   = PAT_NONE;
        cnt_nxt   = '0;
        idx_nxt   = '0;
        loop_nxt  = 1'b0;
        level_nxt = '0;
        reprog    = 1'b1;
      end
      CMD_PLAY: begin
        pat_nxt  = cmd.pat;
        cnt_nxt  = cmd.cnt;
        idx_nxt  = '0;
        loop_nxt = cmd.loop_en;
        sel_pat  = cmd.pat;
        if (cmd.cnt != '0) begin
          start  = 1'b1;
          reprog = 1'b1;
        end
      end
      CMD_STOP: begin
        level_nxt = '0;
        idx_nxt   = cnt_r;
        loop_nxt  = 1'b0;
        reprog    = 1'b1;
      end
      CMD_TICK: begin
        if (idx_r < cnt_r && due) begin
          reprog = 1'b1;
          if (idx_inc >= cnt_r) begin
            if (loop_r) begin
              idx_nxt = '0;
              start   = 1'b1;
            end else begin
              idx_nxt   = idx_inc;
              level_nxt = '0;
            end
          end else begin
            idx_nxt = idx_inc;
            sel_idx = idx_inc;
            start   = 1'b1;
          end
        end
      end
      CMD_NOP: ;
      default: ;
    endcase

    // note start: tone lookup and new deadline
    note = note_rom(sel_pat, sel_idx);
    lane = LANE_W'(note.code - 1'b1);
    quot = div.quot[lane];
    if (start) begin
      deadline_nxt = cmd.now_us + TIME_W'(note.dur_us);
      if (note.code == TONE_SILENT) begin
        level_nxt = '0;
      end else begin
        wrap_nxt  = WRAP_W'(quot);
        level_nxt = LEVEL_W'(quot >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= PAT_NONE;
      cnt_r       <= '0;
      idx_r       <= '0;
      loop_r      <= 1'b0;
      deadline_r  <= '0;
      wrap_r      <= WRAP_RST;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_pop) begin
        pat_r       <= pat_nxt;
        cnt_r       <= cnt_nxt;
        idx_r       <= idx_nxt;
        loop_r      <= loop_nxt;
        deadline_r  <= deadline_nxt;
        wrap_r      <= wrap_nxt;
        level_r     <= level_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      playing_r <= (idx_nxt < cnt_nxt);
      reprog_r  <= reprog;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.tone_wrap    = wrap_r;
  assign out_chan.tone_level   = level_r;
  assign out_chan.playing      = playing_r;
  assign out_chan.reprogrammed = reprog_r;

endmodule
